/* rtl/u8va_pkg.sv */
// Package for the UTF-8 Vietnamese to ASCII converter.
// Holds the decoder phase type, the queue entry type and the shared QMARK constant.
package u8va_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SKIP = 3'd1,
        PH_C3   = 3'd2,
        PH_C4   = 3'd3,
        PH_C6   = 3'd4,
        PH_E1A  = 3'd5,
        PH_E1B  = 3'd6
    } phase_t;

    // One decoded input word: up to two characters, or a bare end marker.
    typedef struct packed {
        logic       two;
        logic       v0;
        logic [6:0] ch0;
        logic [6:0] ch1;
        logic       fin;
    } entry_t;

    localparam logic [6:0] QMARK = 7'h3F;

endpackage

/* rtl/u8va_front.sv */
// Front end: accepts input words, runs the UTF-8 decode state machine and
// pushes one entry per word that yields output. Depends on u8va_pkg.
module u8va_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        in_byte,
    input  logic              in_fin,
    input  logic              in_accept,
    output logic              push,
    output u8va_pkg::entry_t  push_entry
);
    import u8va_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [1:0] n;
    logic [6:0] c0, c1;
    logic       is_lead, is_cont;

    function automatic logic [6:0] map_c3(input logic [7:0] b);
        logic [6:0] r;
        r = QMARK;
        if (b >= 8'h80 && b <= 8'h85) r = 7'h41;
        if (b >= 8'hA0 && b <= 8'hA5) r = 7'h61;
        if (b >= 8'h88 && b <= 8'h8B) r = 7'h45;
        if (b >= 8'hA8 && b <= 8'hAB) r = 7'h65;
        if (b >= 8'h8C && b <= 8'h8F) r = 7'h49;
        if (b >= 8'hAC && b <= 8'hAF) r = 7'h69;
        if (b >= 8'h92 && b <= 8'h96) r = 7'h4F;
        if (b >= 8'hB2 && b <= 8'hB6) r = 7'h6F;
        if (b >= 8'h99 && b <= 8'h9C) r = 7'h55;
        if (b >= 8'hB9 && b <= 8'hBC) r = 7'h75;
        if (b == 8'h9D) r = 7'h59;
        if (b == 8'hBD || b == 8'hBF) r = 7'h79;
        return r;
    endfunction

    function automatic logic [6:0] map_c4(input logic [7:0] b);
        logic [6:0] r;
        r = QMARK;
        if (b == 8'h82) r = 7'h41;
        if (b == 8'h83) r = 7'h61;
        if (b == 8'h90) r = 7'h44;
        if (b == 8'h91) r = 7'h64;
        return r;
    endfunction

    function automatic logic [6:0] map_c6(input logic [7:0] b);
        logic [6:0] r;
        r = QMARK;
        if (b == 8'hA0) r = 7'h4F;
        if (b == 8'hA1) r = 7'h6F;
        if (b == 8'hAF) r = 7'h55;
        if (b == 8'hB0) r = 7'h75;
        return r;
    endfunction

    function automatic logic [6:0] map_e1(input logic [7:0] b2, input logic [7:0] b3);
        logic [12:0] cp;
        logic [6:0]  r;
        logic        lo;
        cp = {1'b1, b2[5:0], b3[5:0]};
        lo = cp[0];
        r  = QMARK;
        if (cp >= 13'h1EA0 && cp <= 13'h1EB7) r = lo ? 7'h61 : 7'h41;
        if (cp >= 13'h1EB8 && cp <= 13'h1EC7) r = lo ? 7'h65 : 7'h45;
        if (cp >= 13'h1EC8 && cp <= 13'h1ECB) r = lo ? 7'h69 : 7'h49;
        if (cp >= 13'h1ECC && cp <= 13'h1EE3) r = lo ? 7'h6F : 7'h4F;
        if (cp >= 13'h1EE4 && cp <= 13'h1EF1) r = lo ? 7'h75 : 7'h55;
        if (cp >= 13'h1EF2 && cp <= 13'h1EF9) r = lo ? 7'h79 : 7'h59;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    assign is_cont = (in_byte[7:6] == 2'b10);
    assign is_lead = (in_byte == 8'hC3) || (in_byte == 8'hC4) ||
                     (in_byte == 8'hC6) || (in_byte == 8'hE1);

    always_comb begin
        n          = 2'd0;
        c0         = 7'd0;
        c1         = 7'd0;
        phase_next = phase_reg;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_C3: begin
                n = 2'd1; c0 = map_c3(in_byte); phase_next = PH_IDLE;
            end
            PH_C4: begin
                n = 2'd1; c0 = map_c4(in_byte); phase_next = PH_IDLE;
            end
            PH_C6: begin
                n = 2'd1; c0 = map_c6(in_byte); phase_next = PH_IDLE;
            end
            PH_E1A: begin
                if (in_fin) begin
                    n = 2'd1;
                    c0 = QMARK;
                    phase_next = PH_SKIP;
                    if (!is_cont) begin
                        n  = 2'd2;
                        c1 = in_byte[7] ? QMARK : in_byte[6:0];
                    end
                end else begin
                    held_next  = in_byte;
                    phase_next = PH_E1B;
                end
            end
            PH_E1B: begin
                n = 2'd1; c0 = map_e1(held_reg, in_byte); phase_next = PH_IDLE;
            end
            default: begin
                if (!(phase_reg == PH_SKIP && is_cont)) begin
                    if (!in_byte[7]) begin
                        n = 2'd1; c0 = in_byte[6:0]; phase_next = PH_IDLE;
                    end else if (is_lead && !in_fin) begin
                        unique case (in_byte)
                            8'hC3:   phase_next = PH_C3;
                            8'hC4:   phase_next = PH_C4;
                            8'hC6:   phase_next = PH_C6;
                            default: phase_next = PH_E1A;
                        endcase
                    end else begin
                        n = 2'd1; c0 = QMARK; phase_next = PH_SKIP;
                    end
                end
            end
        endcase
        if (in_fin) begin
            phase_next = PH_IDLE;
            held_next  = 8'h00;
        end
    end

    assign push           = in_accept && ((n != 2'd0) || in_fin);
    assign push_entry.two = (n == 2'd2);
    assign push_entry.v0  = (n != 2'd0);
    assign push_entry.ch0 = c0;
    assign push_entry.ch1 = c1;
    assign push_entry.fin = in_fin;

endmodule

/* rtl/u8va_queue.sv */
// Small FIFO of decoded entries between the front end and the output side.
// Depends on u8va_pkg for the entry type.
module u8va_queue #(
    parameter int ADDR_W = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  u8va_pkg::entry_t  push_entry,
    input  logic              pop,
    output u8va_pkg::entry_t  head,
    output logic              empty,
    output logic              full
);
    import u8va_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    entry_t            mem [DEPTH];
    logic [ADDR_W-1:0] wr_reg, rd_reg;
    logic [ADDR_W:0]   count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    assign head  = mem[rd_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (ADDR_W + 1)'(DEPTH));

endmodule

/* rtl/u8va_back.sv */
// Output side: splits queue entries into result words and holds them in an
// output register until taken. Depends on u8va_pkg for the entry type.
module u8va_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  u8va_pkg::entry_t  head,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);
    import u8va_pkg::*;

    logic       valid_reg;
    logic       sub_reg, sub_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       user_reg, user_next;
    logic       load;

    assign load = !empty && (!valid_reg || m_tready);

    always_comb begin
        sub_next  = sub_reg;
        pop       = 1'b0;
        data_next = data_reg;
        last_next = last_reg;
        user_next = user_reg;
        if (load) begin
            if (head.two && !sub_reg) begin
                data_next = {1'b1, head.ch0};
                last_next = 1'b0;
                user_next = 1'b0;
                sub_next  = 1'b1;
            end else begin
                data_next = sub_reg ? {1'b1, head.ch1} : {head.v0, head.ch0};
                last_next = 1'b1;
                user_next = head.fin;
                sub_next  = 1'b0;
                pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end else begin
            sub_reg <= sub_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

/* rtl/utf8_vietnamese_to_ascii_core.sv */
// UTF-8 Vietnamese to ASCII converter, top level. Uses u8va_front, u8va_queue
// and u8va_back. Takes one input word per cycle while the entry queue has room.
// A result is written into the queue and then into the output register; a word
// that yields two results holds the output side for two result words, so the
// sustained output rate is one result word per cycle while m_tready is high.
// Reset is synchronous and active low: decoder, queue pointers and output valid clear.
module utf8_vietnamese_to_ascii_core #(
    parameter int QUEUE_ADDR_W = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char[6:0], char_valid[7]
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // string_end
);
    import u8va_pkg::*;

    entry_t push_entry, head;
    logic   push, pop, empty, full, in_accept;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && !full;

    u8va_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_byte    (s_tdata),
        .in_fin     (s_tlast),
        .in_accept  (in_accept),
        .push       (push),
        .push_entry (push_entry)
    );

    u8va_queue #(
        .ADDR_W (QUEUE_ADDR_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    u8va_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* sim/tb.sv */
// Self-checking testbench for utf8_vietnamese_to_ascii_core.
// Streams UTF-8 strings in, predicts the ASCII results in step with the
// accepted input words and checks every result word; depends on u8va_pkg.
module tb;
    import u8va_pkg::*;

    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] LEAD_C4 = 8'hC4;
    localparam logic [7:0] LEAD_C6 = 8'hC6;
    localparam logic [7:0] LEAD_E1 = 8'hE1;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 1050;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       hold;
        logic       quiet;
    } stim_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       cv;
        logic       rl;
        logic       se;
    } ascii_res_t;

    typedef struct packed {
        logic       got;
        logic [6:0] ch;
    } fresh_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    stim_t      byte_q[$];
    ascii_res_t char_due_q[$];
    phase_t     dec_ph = PH_IDLE;
    logic [7:0] e1_hold = 8'h00;
    int         tx_gap = 0;
    int         rx_stall = 0;
    bit         rx_quiet = 1'b0;
    int         errors = 0;
    int         words_in = 0;
    int         words_out = 0;
    int         strings_out = 0;
    int unsigned cycle_cnt = 0;

    utf8_vietnamese_to_ascii_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // in_byte[7:0]
        .s_tlast  (s_tlast),   // is_final
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // out_char[6:0], char_valid[7]
        .m_tlast  (m_tlast),   // run_last
        .m_tuser  (m_tuser)    // string_end
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic fresh_t fresh_decode(input logic [7:0] b, input logic fin);
        fresh_t r;
        r.got = 1'b1;
        r.ch = QMARK;
        if (b < 8'h80) begin
            r.ch = b[6:0];
            dec_ph = PH_IDLE;
        end else if (b == LEAD_C3 || b == LEAD_C4 || b == LEAD_C6 || b == LEAD_E1) begin
            if (fin) begin
                dec_ph = PH_SKIP;
            end else begin
                r.got = 1'b0;
                dec_ph = (b == LEAD_C3) ? PH_C3 : (b == LEAD_C4) ? PH_C4 :
                         (b == LEAD_C6) ? PH_C6 : PH_E1A;
            end
        end else begin
            dec_ph = PH_SKIP;
        end
        return r;
    endfunction

    task automatic strip_predict(input logic [7:0] b, input logic fin);
        logic [7:0]  chs [2];
        int          n;
        fresh_t      fr;
        logic [15:0] cp;
        logic        low;
        n = 0;
        chs[0] = '0;
        chs[1] = '0;
        case (dec_ph)
            PH_C3: begin
                if (b >= 8'h80 && b <= 8'h85) chs[0] = "A";
                else if (b >= 8'hA0 && b <= 8'hA5) chs[0] = "a";
                else if (b >= 8'h88 && b <= 8'h8B) chs[0] = "E";
                else if (b >= 8'hA8 && b <= 8'hAB) chs[0] = "e";
                else if (b >= 8'h8C && b <= 8'h8F) chs[0] = "I";
                else if (b >= 8'hAC && b <= 8'hAF) chs[0] = "i";
                else if (b >= 8'h92 && b <= 8'h96) chs[0] = "O";
                else if (b >= 8'hB2 && b <= 8'hB6) chs[0] = "o";
                else if (b >= 8'h99 && b <= 8'h9C) chs[0] = "U";
                else if (b >= 8'hB9 && b <= 8'hBC) chs[0] = "u";
                else if (b == 8'h9D) chs[0] = "Y";
                else if (b == 8'hBD || b == 8'hBF) chs[0] = "y";
                else chs[0] = {1'b0, QMARK};
                n = 1;
                dec_ph = PH_IDLE;
            end
            PH_C4: begin
                case (b)
                    8'h82: chs[0] = "A";
                    8'h83: chs[0] = "a";
                    8'h90: chs[0] = "D";
                    8'h91: chs[0] = "d";
                    default: chs[0] = {1'b0, QMARK};
                endcase
                n = 1;
                dec_ph = PH_IDLE;
            end
            PH_C6: begin
                case (b)
                    8'hA0: chs[0] = "O";
                    8'hA1: chs[0] = "o";
                    8'hAF: chs[0] = "U";
                    8'hB0: chs[0] = "u";
                    default: chs[0] = {1'b0, QMARK};
                endcase
                n = 1;
                dec_ph = PH_IDLE;
            end
            PH_E1A: begin
                if (fin) begin
                    chs[0] = {1'b0, QMARK};
                    n = 1;
                    dec_ph = PH_SKIP;
                    if (b[7:6] != 2'b10) begin
                        fr = fresh_decode(b, 1'b1);
                        if (fr.got) begin
                            chs[1] = {1'b0, fr.ch};
                            n = 2;
                        end
                    end
                end else begin
                    e1_hold = b;
                    dec_ph = PH_E1B;
                end
            end
            PH_E1B: begin
                cp = {4'h1, e1_hold[5:0], b[5:0]};
                low = cp[0];
                if (cp >= 16'h1EA0 && cp <= 16'h1EB7) chs[0] = low ? "a" : "A";
                else if (cp >= 16'h1EB8 && cp <= 16'h1EC7) chs[0] = low ? "e" : "E";
                else if (cp >= 16'h1EC8 && cp <= 16'h1ECB) chs[0] = low ? "i" : "I";
                else if (cp >= 16'h1ECC && cp <= 16'h1EE3) chs[0] = low ? "o" : "O";
                else if (cp >= 16'h1EE4 && cp <= 16'h1EF1) chs[0] = low ? "u" : "U";
                else if (cp >= 16'h1EF2 && cp <= 16'h1EF9) chs[0] = low ? "y" : "Y";
                else chs[0] = {1'b0, QMARK};
                n = 1;
                dec_ph = PH_IDLE;
            end
            default: begin
                if (!(dec_ph == PH_SKIP && b[7:6] == 2'b10)) begin
                    fr = fresh_decode(b, fin);
                    if (fr.got) begin
                        chs[0] = {1'b0, fr.ch};
                        n = 1;
                    end
                end
            end
        endcase
        for (int i = 0; i < n; i++) begin
            char_due_q.push_back('{chs[i][6:0], 1'b1, i == n - 1, fin && (i == n - 1)});
        end
        if (fin) begin
            if (n == 0) char_due_q.push_back('{7'h00, 1'b0, 1'b1, 1'b1});
            dec_ph = PH_IDLE;
            e1_hold = 8'h00;
        end
    endtask

    // Driver: each word waits its drawn gap; a hold word waits for the output side to drain.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (byte_q.size() != 0 &&
                         !(byte_q[0].hold &&
                           (s_tvalid || char_due_q.size() != 0 || m_tvalid))) begin
                s_tdata <= byte_q[0].b;
                s_tlast <= byte_q[0].fin;
                s_tvalid <= 1'b1;
                rx_quiet = byte_q[0].quiet;
                tx_gap <= byte_q[0].quiet ? 0 : $urandom_range(0, 14);
                void'(byte_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks result words against the predictions, then predicts from the input word.
    always @(posedge aclk) begin
        ascii_res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[6:0], m_tdata[7], m_tlast, m_tuser};
                words_out++;
                if (m_tuser) strings_out++;
                if (char_due_q.size() == 0) begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t: unexpected result word, actual %h", $time, got);
                end else begin
                    want = char_due_q.pop_front();
                    if (got !== want || m_tdata[7] === 1'bx) begin
                        errors++;
                        if (errors <= 20)
                            $display({"%0t: mismatch, expected ch=%h cv=%b rl=%b se=%b,",
                                      " actual ch=%h cv=%b rl=%b se=%b"},
                                     $time, want.ch, want.cv, want.rl, want.se,
                                     got.ch, got.cv, got.rl, got.se);
                    end
                end
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 14);
                m_tready <= (rx_stall == 0);
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if (s_tvalid && s_tready) begin
                words_in++;
                strip_predict(s_tdata, s_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, char_due_q.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fin, input bit hold, input bit quiet);
        byte_q.push_back('{b, fin, hold, quiet});
    endtask

    task automatic queue_string(input bit quiet, input bit hold);
        logic [7:0] seq[$];
        int         nch;
        int         kind;
        logic [7:0] lead;
        nch = $urandom_range(1, 10);
        repeat (nch) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                seq.push_back(8'($urandom_range(0, 127)));
            end else if (kind < 45) begin
                seq.push_back(LEAD_C3);
                seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else if (kind < 52) begin
                seq.push_back(LEAD_C4);
                seq.push_back(8'($urandom_range(8'h80, 8'h93)));
            end else if (kind < 59) begin
                seq.push_back(LEAD_C6);
                seq.push_back(8'($urandom_range(8'h9E, 8'hB2)));
            end else if (kind < 82) begin
                seq.push_back(LEAD_E1);
                if ($urandom_range(0, 3) == 0) seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
                else seq.push_back($urandom_range(0, 1) ? 8'hBA : 8'hBB);
                seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else if (kind < 92) begin
                seq.push_back(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else begin
                case ($urandom_range(0, 3))
                    0: lead = LEAD_C3;
                    1: lead = LEAD_C4;
                    2: lead = LEAD_C6;
                    default: lead = LEAD_E1;
                endcase
                seq.push_back(lead);
                seq.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            seq.push_back(LEAD_E1);
            if ($urandom_range(0, 1)) seq.push_back(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 9) == 0) begin
            seq.push_back($urandom_range(0, 1) ? LEAD_C3 : LEAD_C6);
        end
        foreach (seq[i]) push_byte(seq[i], i == seq.size() - 1, hold && i == 0, quiet);
    endtask

    initial begin
        logic [8:0] directed [];
        int n_strings;
        directed = '{
            9'h000, 9'h17F,
            9'h0C3, 9'h0BF, 9'h0C4, 9'h090, 9'h0C6, 9'h1B0,
            9'h0E1, 9'h0BA, 9'h1A0,
            9'h1C3,
            9'h1E1,
            9'h0E1, 9'h180,
            9'h0E1, 9'h141,
            9'h0E1, 9'h1C3,
            9'h0FF, 9'h080, 9'h162,
            9'h0C0, 9'h180,
            9'h0C3, 9'h141
        };
        n_strings = 0;
        foreach (directed[i]) push_byte(directed[i][7:0], directed[i][8], 1'b0, 1'b0);
        while (byte_q.size() < BYTE_TARGET + directed.size()) begin
            queue_string($urandom_range(0, 4) == 0, (n_strings % 12) == 5);
            n_strings++;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (byte_q.size() != 0 || s_tvalid || char_due_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Sent %0d input words in %0d strings; checked %0d result words, %0d string ends.",
                 words_in, n_strings + 11, words_out, strings_out);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/u8va_pkg.sv
rtl/u8va_front.sv
rtl/u8va_queue.sv
rtl/u8va_back.sv
rtl/utf8_vietnamese_to_ascii_core.sv
sim/tb.sv
